### rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared widths, limits and register codes for the pair force pipe
// Fixed-point widths of every datapath stage and the register map.
// ----------------------------------------------------------------------------
package spf_pkg;

	// Axes and field widths
	localparam int NAX   = 3;   // x, y, z
	localparam int PW    = 32;  // position, signed Q15.16
	localparam int MW    = 32;  // mass, unsigned Q16.16
	localparam int CW    = 32;  // configuration data
	localparam int FW    = 48;  // force, signed Q31.16
	localparam int ADDRW = 3;   // byte address of two 32-bit registers

	// Datapath widths
	localparam int UW    = 32;            // |r| per axis
	localparam int PRW   = 2 * UW;        // 32x32 product
	localparam int SQW   = PRW - 16;      // (|r|^2) >> 16
	localparam int D2W   = 50;            // softened squared distance
	localparam int NUMW  = 96;            // G * ma * mb, Q.48
	localparam int QW    = 79;            // quotient bits that are ever needed
	localparam int NHW   = NUMW - QW;     // numerator bits above the quotient
	localparam int S2W   = QW - 2 * UW;   // top slice of the quotient
	localparam int P2W   = S2W + UW;      // top partial product
	localparam int AW1   = PRW + 1;       // first partial sum
	localparam int MAGW  = QW;            // (s * |r|) >> 32

	// Saturation limits
	localparam logic [FW-1:0] POS_LIM = {1'b0, {(FW-1){1'b1}}};
	localparam logic [FW-1:0] NEG_LIM = {1'b1, {(FW-1){1'b0}}};

	// Register index codes, taken from paddr[2]
	localparam logic REG_GRAV = 1'b0;
	localparam logic REG_SOFT = 1'b1;

	// Register reset values
	localparam logic [CW-1:0] GRAV_RST = 32'h0001_0000;
	localparam logic [CW-1:0] SOFT_RST = 32'h0000_1000;

	// Per-axis distance magnitude and sign
	typedef struct packed {
		logic [NAX-1:0][UW-1:0] mag;
		logic [NAX-1:0]         neg;
	} geom_t;

	// One stage of the restoring divider
	typedef struct packed {
		logic [D2W-1:0] d2;
		logic [D2W-1:0] rem;
		logic [QW-1:0]  nq;   // numerator bits still to come, quotient bits shifted in
		logic           big;  // quotient at or above 2^79: every nonzero axis saturates
		geom_t          g;
	} div_t;

endpackage

### rtl/softened_pair_force.sv
// ----------------------------------------------------------------------------
// softened_pair_force: throughput one pair per cycle while the skid entry
// is empty; the 79-step divider pipeline sets the depth. A two-entry output
// (register plus skid) parks one result in the skid under stall while the pipe
// holds. arst_n clears valid bits and loads G = 1.0 and soft^2 = 0.0625.
// ----------------------------------------------------------------------------
module softened_pair_force (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spf_pkg::ADDRW-1:0]    paddr,
	input  logic [spf_pkg::CW-1:0]       pwdata,
	output logic [spf_pkg::CW-1:0]       prdata,
	output logic                         pready,
	// pair input
	input  logic                         pair_valid,
	output logic                         pair_stall,
	input  logic signed [spf_pkg::PW-1:0] first_x,
	input  logic signed [spf_pkg::PW-1:0] first_y,
	input  logic signed [spf_pkg::PW-1:0] first_z,
	input  logic [spf_pkg::MW-1:0]       first_mass,
	input  logic signed [spf_pkg::PW-1:0] second_x,
	input  logic signed [spf_pkg::PW-1:0] second_y,
	input  logic signed [spf_pkg::PW-1:0] second_z,
	input  logic [spf_pkg::MW-1:0]       second_mass,
	// force output
	output logic                         force_valid,
	input  logic                         force_stall,
	output logic signed [spf_pkg::FW-1:0] force_x,
	output logic signed [spf_pkg::FW-1:0] force_y,
	output logic signed [spf_pkg::FW-1:0] force_z,
	output logic                         clipped
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [spf_pkg::CW-1:0] grav_q;
	logic [spf_pkg::CW-1:0] soft_q;
	logic                   cfg_wr;
	logic                   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[spf_pkg::ADDRW-1];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign prdata  = (cfg_idx == spf_pkg::REG_SOFT) ? soft_q : grav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= spf_pkg::GRAV_RST;
			soft_q <= spf_pkg::SOFT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				spf_pkg::REG_GRAV: grav_q <= pwdata;
				spf_pkg::REG_SOFT: soft_q <= pwdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipe advances unless the skid entry is full
	// ------------------------------------------------------------------
	logic adv;
	logic skid_valid_q;
	logic force_valid_q;

	assign adv        = ~skid_valid_q;
	assign pair_stall = skid_valid_q;

	// ------------------------------------------------------------------
	// Stage 1: difference vector, |r| and sign per axis, G * ma
	// ------------------------------------------------------------------
	logic [spf_pkg::NAX-1:0][spf_pkg::PW-1:0] first_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::PW-1:0] second_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::PW:0]   diff_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::PW:0]   abs_c;
	spf_pkg::geom_t                           geom_c;

	assign first_c  = {first_z, first_y, first_x};
	assign second_c = {second_z, second_y, second_x};

	always_comb begin
		for (int i = 0; i < spf_pkg::NAX; i++) begin
			diff_c[i] = {second_c[i][spf_pkg::PW-1], second_c[i]}
			          - {first_c[i][spf_pkg::PW-1], first_c[i]};
			abs_c[i]  = diff_c[i][spf_pkg::PW] ? ((spf_pkg::PW+1)'(0) - diff_c[i]) : diff_c[i];
			geom_c.neg[i] = diff_c[i][spf_pkg::PW];
			geom_c.mag[i] = abs_c[i][spf_pkg::UW-1:0];
		end
	end

	logic                     vld_s1;
	spf_pkg::geom_t           g_s1;
	logic [spf_pkg::PRW-1:0]  gm_s1;
	logic [spf_pkg::MW-1:0]   mb_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1  <= geom_c;
			gm_s1 <= spf_pkg::PRW'(grav_q) * spf_pkg::PRW'(first_mass);
			mb_s1 <= second_mass;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squares per axis, two halves of G * ma * mb
	// ------------------------------------------------------------------
	logic [spf_pkg::NAX-1:0][spf_pkg::PRW-1:0] sqf_c;

	always_comb begin
		for (int i = 0; i < spf_pkg::NAX; i++) begin
			sqf_c[i] = spf_pkg::PRW'(g_s1.mag[i]) * spf_pkg::PRW'(g_s1.mag[i]);
		end
	end

	logic                                       vld_s2;
	spf_pkg::geom_t                             g_s2;
	logic [spf_pkg::NAX-1:0][spf_pkg::SQW-1:0]  sq_s2;
	logic [spf_pkg::PRW-1:0]                    pl_s2;
	logic [spf_pkg::PRW-1:0]                    ph_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s2 <= g_s1;
			for (int i = 0; i < spf_pkg::NAX; i++) begin
				sq_s2[i] <= sqf_c[i][spf_pkg::PRW-1:16];
			end
			pl_s2 <= spf_pkg::PRW'(gm_s1[spf_pkg::UW-1:0]) * spf_pkg::PRW'(mb_s1);
			ph_s2 <= spf_pkg::PRW'(gm_s1[spf_pkg::PRW-1:spf_pkg::UW]) * spf_pkg::PRW'(mb_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: partial distance sums, full numerator
	// ------------------------------------------------------------------
	logic                      vld_s3;
	spf_pkg::geom_t            g_s3;
	logic [spf_pkg::SQW:0]     sa_s3;
	logic [spf_pkg::SQW:0]     sb_s3;
	logic [spf_pkg::NUMW-1:0]  num_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s3   <= g_s2;
			sa_s3  <= (spf_pkg::SQW+1)'(sq_s2[0]) + (spf_pkg::SQW+1)'(sq_s2[1]);
			sb_s3  <= (spf_pkg::SQW+1)'(sq_s2[2]) + (spf_pkg::SQW+1)'(soft_q);
			num_s3 <= spf_pkg::NUMW'(pl_s2) + {ph_s2, {spf_pkg::UW{1'b0}}};
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 (divider entry): d2, zero distance forced to one LSB
	// ------------------------------------------------------------------
	spf_pkg::div_t           div_s  [spf_pkg::QW+1];
	logic                    dvld_s [spf_pkg::QW+1];
	logic [spf_pkg::D2W-1:0] d2sum_c;

	assign d2sum_c = spf_pkg::D2W'(sa_s3) + spf_pkg::D2W'(sb_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].d2  <= (d2sum_c == '0) ? spf_pkg::D2W'(1) : d2sum_c;
			div_s[0].rem <= spf_pkg::D2W'(num_s3[spf_pkg::NUMW-1:spf_pkg::QW]);
			div_s[0].nq  <= num_s3[spf_pkg::QW-1:0];
			div_s[0].big <= 1'b0;
			div_s[0].g   <= g_s3;
		end
	end

	// Front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			dvld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1    <= pair_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			dvld_s[0] <= vld_s3;
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider: one quotient bit per stage, MSB first
	// ------------------------------------------------------------------
	genvar k;
	generate
		for (k = 1; k <= spf_pkg::QW; k++) begin : g_div
			logic [spf_pkg::D2W:0] trial;
			logic [spf_pkg::D2W:0] dsub;
			logic [spf_pkg::D2W:0] dext;
			logic                  ge;
			logic                  big_n;

			assign dext  = {1'b0, div_s[k-1].d2};
			assign trial = {div_s[k-1].rem, div_s[k-1].nq[spf_pkg::QW-1]};
			assign dsub  = trial - dext;
			assign ge    = (trial >= dext);

			// first step also flags a quotient too large for any nonzero axis
			if (k == 1) begin : g_big
				assign big_n = (div_s[0].rem >= div_s[0].d2);
			end else begin : g_pass
				assign big_n = div_s[k-1].big;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					div_s[k].d2  <= div_s[k-1].d2;
					div_s[k].rem <= ge ? dsub[spf_pkg::D2W-1:0] : trial[spf_pkg::D2W-1:0];
					div_s[k].nq  <= {div_s[k-1].nq[spf_pkg::QW-2:0], ge};
					div_s[k].big <= big_n;
					div_s[k].g   <= div_s[k-1].g;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dvld_s[k] <= 1'b0;
				end else if (adv) begin
					dvld_s[k] <= dvld_s[k-1];
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Stage 5: quotient slices times |r| per axis
	// ------------------------------------------------------------------
	logic [spf_pkg::QW-1:0]                     quo_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::PRW-1:0]  p0_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::PRW-1:0]  p1_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::P2W-1:0]  p2_c;
	logic [spf_pkg::NAX-1:0]                    nz_c;

	assign quo_c = div_s[spf_pkg::QW].nq;

	always_comb begin
		for (int i = 0; i < spf_pkg::NAX; i++) begin
			p0_c[i] = spf_pkg::PRW'(quo_c[spf_pkg::UW-1:0])
			        * spf_pkg::PRW'(div_s[spf_pkg::QW].g.mag[i]);
			p1_c[i] = spf_pkg::PRW'(quo_c[2*spf_pkg::UW-1:spf_pkg::UW])
			        * spf_pkg::PRW'(div_s[spf_pkg::QW].g.mag[i]);
			p2_c[i] = spf_pkg::P2W'(quo_c[spf_pkg::QW-1:2*spf_pkg::UW])
			        * spf_pkg::P2W'(div_s[spf_pkg::QW].g.mag[i]);
			nz_c[i] = |div_s[spf_pkg::QW].g.mag[i];
		end
	end

	logic                                       vld_s5;
	logic                                       big_s5;
	logic [spf_pkg::NAX-1:0]                    neg_s5;
	logic [spf_pkg::NAX-1:0]                    nz_s5;
	logic [spf_pkg::NAX-1:0][spf_pkg::PRW-1:0]  p0_s5;
	logic [spf_pkg::NAX-1:0][spf_pkg::PRW-1:0]  p1_s5;
	logic [spf_pkg::NAX-1:0][spf_pkg::P2W-1:0]  p2_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s5 <= div_s[spf_pkg::QW].big;
			neg_s5 <= div_s[spf_pkg::QW].g.neg;
			nz_s5  <= nz_c;
			p0_s5  <= p0_c;
			p1_s5  <= p1_c;
			p2_s5  <= p2_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: middle partial sum (bits below 2^32 drop out)
	// ------------------------------------------------------------------
	logic                                       vld_s6;
	logic                                       big_s6;
	logic [spf_pkg::NAX-1:0]                    neg_s6;
	logic [spf_pkg::NAX-1:0]                    nz_s6;
	logic [spf_pkg::NAX-1:0][spf_pkg::AW1-1:0]  a_s6;
	logic [spf_pkg::NAX-1:0][spf_pkg::P2W-1:0]  p2_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s6 <= big_s5;
			neg_s6 <= neg_s5;
			nz_s6  <= nz_s5;
			p2_s6  <= p2_s5;
			for (int i = 0; i < spf_pkg::NAX; i++) begin
				a_s6[i] <= spf_pkg::AW1'(p0_s5[i][spf_pkg::PRW-1:spf_pkg::UW])
				         + spf_pkg::AW1'(p1_s5[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: force magnitude (s * |r|) >> 32
	// ------------------------------------------------------------------
	logic                                        vld_s7;
	logic                                        big_s7;
	logic [spf_pkg::NAX-1:0]                     neg_s7;
	logic [spf_pkg::NAX-1:0]                     nz_s7;
	logic [spf_pkg::NAX-1:0][spf_pkg::MAGW-1:0]  mag_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s7 <= big_s6;
			neg_s7 <= neg_s6;
			nz_s7  <= nz_s6;
			for (int i = 0; i < spf_pkg::NAX; i++) begin
				mag_s7[i] <= spf_pkg::MAGW'(a_s6[i]) + {p2_s6[i], {spf_pkg::UW{1'b0}}};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: saturation, sign, clip flag
	// ------------------------------------------------------------------
	logic [spf_pkg::NAX-1:0]                    ovf_c;
	logic [spf_pkg::NAX-1:0]                    sat_c;
	logic [spf_pkg::NAX-1:0][spf_pkg::FW-1:0]   frc_c;

	always_comb begin
		for (int i = 0; i < spf_pkg::NAX; i++) begin
			if (neg_s7[i]) begin
				ovf_c[i] = (|mag_s7[i][spf_pkg::MAGW-1:spf_pkg::FW])
				         | (mag_s7[i][spf_pkg::FW-1] & (|mag_s7[i][spf_pkg::FW-2:0]));
			end else begin
				ovf_c[i] = |mag_s7[i][spf_pkg::MAGW-1:spf_pkg::FW-1];
			end
			sat_c[i] = nz_s7[i] & (big_s7 | ovf_c[i]);
			if (!nz_s7[i]) begin
				frc_c[i] = '0;
			end else if (sat_c[i]) begin
				frc_c[i] = neg_s7[i] ? spf_pkg::NEG_LIM : spf_pkg::POS_LIM;
			end else if (neg_s7[i]) begin
				frc_c[i] = spf_pkg::FW'(0) - mag_s7[i][spf_pkg::FW-1:0];
			end else begin
				frc_c[i] = mag_s7[i][spf_pkg::FW-1:0];
			end
		end
	end

	logic                                       vld_s8;
	logic [spf_pkg::NAX-1:0][spf_pkg::FW-1:0]   frc_s8;
	logic                                       clip_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			frc_s8  <= frc_c;
			clip_s8 <= |sat_c;
		end
	end

	// Back valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= dvld_s[spf_pkg::QW];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid entry
	// ------------------------------------------------------------------
	logic                                       out_free;
	logic [spf_pkg::NAX-1:0][spf_pkg::FW-1:0]   frc_q;
	logic                                       clip_q;
	logic [spf_pkg::NAX-1:0][spf_pkg::FW-1:0]   skid_frc_q;
	logic                                       skid_clip_q;

	assign out_free = ~force_valid_q | ~force_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_valid_q <= 1'b0;
			skid_valid_q  <= 1'b0;
		end else if (out_free) begin
			force_valid_q <= skid_valid_q | (adv & vld_s8);
			skid_valid_q  <= 1'b0;
		end else if (adv & vld_s8) begin
			skid_valid_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			frc_q  <= skid_valid_q ? skid_frc_q  : frc_s8;
			clip_q <= skid_valid_q ? skid_clip_q : clip_s8;
		end else if (adv) begin
			skid_frc_q  <= frc_s8;
			skid_clip_q <= clip_s8;
		end
	end

	assign force_valid = force_valid_q;
	assign force_x     = frc_q[0];
	assign force_y     = frc_q[1];
	assign force_z     = frc_q[2];
	assign clipped     = clip_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// skid only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> force_valid_q)
		else $error("skid entry valid with empty output register");

	// skid fills only when the output transfer was refused
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(force_valid_q & force_stall))
		else $error("skid entry filled without an output stall");

	// a clip flag always comes with a component at a limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(force_valid_q && clip_q) |->
			(frc_q[0] == spf_pkg::POS_LIM || frc_q[0] == spf_pkg::NEG_LIM ||
			 frc_q[1] == spf_pkg::POS_LIM || frc_q[1] == spf_pkg::NEG_LIM ||
			 frc_q[2] == spf_pkg::POS_LIM || frc_q[2] == spf_pkg::NEG_LIM))
		else $error("clip flag set with no saturated component");

endmodule
